// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the change trigger.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, muted while reset is held.
`define SDCT_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);

// Clocked next-cycle implication check, muted while reset is held.
`define SDCT_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

// ----- hw/rtl/sdct_pkg.sv -----
// Package of the change trigger: widths, codes, defaults and stage structs.
`timescale 1ns / 1ps

package sdct_pkg;

  // Fixed field widths
  localparam int OP_W      = 2;
  localparam int CH_W      = 6;
  localparam int DATA_W    = 32;
  localparam int GAIN_W    = 32;
  localparam int TOL_W     = 31;
  localparam int CFG_IDX_W = 1;

  // Parameter defaults
  localparam int DEF_CHANNELS    = 64;
  localparam int DEF_SAMPLE_BITS = 32;

  // Register reset values and the prepulse store time
  localparam logic [GAIN_W-1:0] GAIN_RST       = 32'd4295;
  localparam logic [TOL_W-1:0]  TOL_RST        = 31'd0;
  localparam logic [DATA_W-1:0] STORE_TIME_RST = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] PREPULSE_TIME  = 32'd0;

  // Frame operations
  typedef enum logic [OP_W-1:0] {
    OP_ONLINE    = 2'd0,
    OP_PREPULSE  = 2'd1,
    OP_POSTPULSE = 2'd2,
    OP_OTHER     = 2'd3
  } sdct_op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN = 1'b0,
    CFG_TOL  = 1'b1
  } sdct_cfg_t;

  // Online acquisition phase
  typedef enum logic [2:0] {
    PH_WARMUP = 3'b001,
    PH_FIRST  = 3'b010,
    PH_STEADY = 3'b100
  } sdct_phase_t;

  // Accepted input item
  typedef struct packed {
    sdct_op_t            op;
    logic [CH_W-1:0]     channel;
    logic [DATA_W-1:0]   sample;
    logic [DATA_W-1:0]   stime;
    logic                last;
  } sdct_item_t;

  // Fields carried along the pipeline unchanged
  typedef struct packed {
    sdct_op_t            op;
    logic [CH_W-1:0]     channel;
    logic [DATA_W-1:0]   stime;
    logic                last;
  } sdct_tag_t;

  // Datapath to frame controller
  typedef struct packed {
    sdct_tag_t           tag;
    logic [DATA_W-1:0]   prev;
    logic                trig;
  } sdct_cmp_t;

  // Result item
  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [DATA_W-1:0]   prev;
    logic                frame_done;
    logic                store_request;
    logic                store_flag;
    logic [DATA_W-1:0]   store_time;
  } sdct_res_t;

endpackage

// ----- hw/rtl/sdct_if.sv -----
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps

interface sdct_in_if import sdct_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [CH_W-1:0]          channel;
  logic signed [DATA_W-1:0] sample_value;
  logic signed [DATA_W-1:0] sample_time;
  logic                     last_channel;

  modport source (
    output valid, operation, channel, sample_value, sample_time, last_channel,
    input  ready
  );
  modport sink (
    input  valid, operation, channel, sample_value, sample_time, last_channel,
    output ready
  );
endinterface

interface sdct_out_if import sdct_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CH_W-1:0]          channel_out;
  logic signed [DATA_W-1:0] previous_value;
  logic                     frame_done;
  logic                     store_request;
  logic                     store_flag;
  logic signed [DATA_W-1:0] store_time;

  modport source (
    output valid, channel_out, previous_value, frame_done, store_request, store_flag,
           store_time,
    input  ready
  );
  modport sink (
    input  valid, channel_out, previous_value, frame_done, store_request, store_flag,
           store_time,
    output ready
  );
endinterface

// ----- hw/rtl/second_difference_change_trigger.sv -----
// Top level of the second-difference change trigger.
//
//  Channel  Dir  Handshake     Payload
//  in_chan  in   valid/ready   operation, channel, sample_value, sample_time, last_channel
//  out_chan out  valid/ready   channel_out, previous_value, frame_done, store_request,
//                              store_flag, store_time
//  cfg_*    in   cfg_we        cfg_index, cfg_wdata (0 gain, 1 tolerance)
//
// One item per clock sustained while the output accepts results; a result reaches the output
// register through the store read, multiply and compare stage registers.
// Synchronous active-low reset clears all valids, store valid bits and frame state; there is
// no clearing pass.
// A stalled output holds the pipeline; in_chan.ready falls only when every stage is full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module second_difference_change_trigger import sdct_pkg::*; #(
  parameter int CHANNELS    = DEF_CHANNELS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  sdct_in_if.sink              in_chan,
  sdct_out_if.source           out_chan
);

  logic [GAIN_W-1:0] gain_r;
  logic [TOL_W-1:0]  tol_r;
  sdct_item_t        in_item;
  logic              cmp_valid, cmp_ready;
  sdct_cmp_t         cmp_item;
  sdct_res_t         out_res;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RST;
      tol_r  <= TOL_RST;
    end else if (cfg_we) begin
      case (sdct_cfg_t'(cfg_index))
        CFG_GAIN: begin
          gain_r <= cfg_wdata[GAIN_W-1:0];
        end
        CFG_TOL: begin
          tol_r <= cfg_wdata[TOL_W-1:0];
        end
        default: begin
          gain_r <= gain_r;
        end
      endcase
    end
  end

  // Pack the input transfer
  assign in_item = '{op: sdct_op_t'(in_chan.operation), channel: in_chan.channel,
                     sample: in_chan.sample_value, stime: in_chan.sample_time,
                     last: in_chan.last_channel};

  sdct_datapath #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_item   (in_item),
    .gain      (gain_r),
    .tol       (tol_r),
    .cmp_valid (cmp_valid),
    .cmp_ready (cmp_ready),
    .cmp_item  (cmp_item)
  );

  sdct_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmp_valid (cmp_valid),
    .cmp_ready (cmp_ready),
    .cmp_item  (cmp_item),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  // Drive the result channel
  assign out_chan.channel_out    = out_res.channel;
  assign out_chan.previous_value = out_res.prev;
  assign out_chan.frame_done     = out_res.frame_done;
  assign out_chan.store_request  = out_res.store_request;
  assign out_chan.store_flag     = out_res.store_flag;
  assign out_chan.store_time     = out_res.store_time;

  // Checks
  `SDCT_ASSERT_IMP(a_store_at_frame_end, clk, rst_n,
    out_chan.valid && out_chan.store_request, out_chan.frame_done,
    "store request on a result that does not end a frame")
  `SDCT_ASSERT_IMP(a_flag_needs_store, clk, rst_n,
    out_chan.valid && out_chan.store_flag, out_chan.store_request,
    "store flag set without a store request")
  `SDCT_ASSERT_IMP(a_stall_from_output, clk, rst_n,
    !in_chan.ready, out_chan.valid && !out_chan.ready,
    "input stalled while the result side is free")
  `SDCT_ASSERT_NXT(a_cfg_gain_write, clk, rst_n,
    cfg_we && (cfg_index == CFG_GAIN), gain_r == $past(cfg_wdata),
    "gain register missed a write")

endmodule

// ----- hw/rtl/sdct_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sdct_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/sdct_datapath.sv -----
// Sample and difference stores, first/second difference and bound compare pipeline.
`timescale 1ns / 1ps

module sdct_datapath import sdct_pkg::*; #(
  parameter int CHANNELS    = DEF_CHANNELS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sdct_item_t        in_item,
  input  logic [GAIN_W-1:0] gain,
  input  logic [TOL_W-1:0]  tol,
  output logic              cmp_valid,
  input  logic              cmp_ready,
  output sdct_cmp_t         cmp_item
);

  localparam int AW    = $clog2(CHANNELS);
  localparam int S     = SAMPLE_BITS;
  localparam int PW    = GAIN_W + S;
  localparam int CMP_W = ((S > TOL_W) ? S : TOL_W) + 2;
  localparam logic signed [S-1:0] SMAX = {1'b0, {(S-1){1'b1}}};
  localparam logic signed [S-1:0] SMIN = {1'b1, {(S-1){1'b0}}};
  localparam logic [CH_W:0]       CH_LIMIT = (CH_W+1)'(CHANNELS);

  // Stage handshake
  logic rd_v_r, mul_v_r, cmp_v_r;
  logic rd_ready, mul_ready, cmp_stage_ready;
  logic rd_go;

  // Read stage
  sdct_item_t              rd_item_r;
  logic [AW-1:0]           rd_addr;
  logic                    rd_inr;
  logic signed [S-1:0]     cur;
  logic signed [S-1:0]     prev;
  logic signed [S-1:0]     pd;
  logic signed [S:0]       diff_full;
  logic signed [S-1:0]     diff_sat;
  logic [S-1:0]            aprev;
  logic [S-1:0]            samp_rdata, diff_rdata;
  logic                    samp_we, diff_we;
  logic                    samp_hit, diff_hit;
  logic [CHANNELS-1:0]     samp_vld_r, diff_vld_r;

  // Last write into each store, for reads that cross it
  logic                    byp_s_v_r, byp_d_v_r;
  logic [AW-1:0]           byp_s_ch_r, byp_d_ch_r;
  logic [S-1:0]            byp_s_val_r, byp_d_val_r;

  // Multiply stage
  sdct_tag_t               mul_tag_r;
  logic [DATA_W-1:0]       mul_prev_r;
  logic                    mul_en_r;
  logic signed [S-1:0]     mul_diff_r, mul_pd_r;
  logic [S-1:0]            mul_aprev_r;
  logic signed [S:0]       dd;
  logic [S:0]              mag;
  logic [PW-1:0]           prod;

  // Compare stage
  sdct_tag_t               cmp_tag_r;
  logic [DATA_W-1:0]       cmp_prev_r;
  logic                    cmp_en_r;
  logic [S:0]              cmp_mag_r;
  logic [S-1:0]            cmp_phi_r;
  logic [CMP_W-1:0]        bound;

  // Ready chain: a stage takes data when empty or when it moves on
  assign cmp_stage_ready = !cmp_v_r || cmp_ready;
  assign mul_ready       = !mul_v_r || cmp_stage_ready;
  assign rd_ready        = !rd_v_r || mul_ready;
  assign in_ready        = rd_ready;
  assign rd_go           = rd_v_r && mul_ready;

  // Stores of previous samples and previous first differences
  sdct_ram #(.WIDTH(S), .DEPTH(CHANNELS)) u_samp_ram (
    .clk     (clk),
    .wr_en   (samp_we),
    .wr_addr (rd_addr),
    .wr_data (cur),
    .rd_en   (in_valid && in_ready),
    .rd_addr (in_item.channel[AW-1:0]),
    .rd_data (samp_rdata)
  );

  sdct_ram #(.WIDTH(S), .DEPTH(CHANNELS)) u_diff_ram (
    .clk     (clk),
    .wr_en   (diff_we),
    .wr_addr (rd_addr),
    .wr_data (diff_sat),
    .rd_en   (in_valid && in_ready),
    .rd_addr (in_item.channel[AW-1:0]),
    .rd_data (diff_rdata)
  );

  // Read stage: resolve stored values, first difference with saturation
  always_comb begin
    rd_addr   = rd_item_r.channel[AW-1:0];
    rd_inr    = {1'b0, rd_item_r.channel} < CH_LIMIT;
    cur       = rd_item_r.sample[S-1:0];
    samp_hit  = byp_s_v_r && (byp_s_ch_r == rd_addr);
    diff_hit  = byp_d_v_r && (byp_d_ch_r == rd_addr);
    prev      = samp_hit ? byp_s_val_r : (samp_vld_r[rd_addr] ? samp_rdata : '0);
    pd        = diff_hit ? byp_d_val_r : (diff_vld_r[rd_addr] ? diff_rdata : '0);
    diff_full = (S+1)'(cur) - (S+1)'(prev);
    if (diff_full[S] != diff_full[S-1]) begin
      diff_sat = diff_full[S] ? SMIN : SMAX;
    end else begin
      diff_sat = diff_full[S-1:0];
    end
    aprev   = prev[S-1] ? $unsigned(-prev) : $unsigned(prev);
    samp_we = rd_go && rd_inr && (rd_item_r.op != OP_PREPULSE);
    diff_we = rd_go && rd_inr && (rd_item_r.channel != '0);
  end

  // Hold valid bits and the last write of each store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samp_vld_r <= '0;
      diff_vld_r <= '0;
      byp_s_v_r  <= 1'b0;
      byp_d_v_r  <= 1'b0;
    end else begin
      if (samp_we) begin
        samp_vld_r[rd_addr] <= 1'b1;
        byp_s_v_r           <= 1'b1;
      end
      if (diff_we) begin
        diff_vld_r[rd_addr] <= 1'b1;
        byp_d_v_r           <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (samp_we) begin
      byp_s_ch_r  <= rd_addr;
      byp_s_val_r <= cur;
    end
    if (diff_we) begin
      byp_d_ch_r  <= rd_addr;
      byp_d_val_r <= diff_sat;
    end
  end

  // Multiply stage: second difference magnitude and gain product
  always_comb begin
    dd   = (S+1)'(mul_diff_r) - (S+1)'(mul_pd_r);
    mag  = dd[S] ? $unsigned(-dd) : $unsigned(dd);
    prod = PW'(gain) * PW'(mul_aprev_r);
  end

  // Compare stage: bound and strict excess
  always_comb begin
    bound    = CMP_W'(cmp_phi_r) + CMP_W'(tol);
    cmp_item = '{tag: cmp_tag_r, prev: cmp_prev_r,
                 trig: cmp_en_r && (CMP_W'(cmp_mag_r) > bound)};
  end
  assign cmp_valid = cmp_v_r;

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
      cmp_v_r <= 1'b0;
    end else begin
      if (rd_ready) begin
        rd_v_r <= in_valid;
      end
      if (mul_ready) begin
        mul_v_r <= rd_v_r;
      end
      if (cmp_stage_ready) begin
        cmp_v_r <= mul_v_r;
      end
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    if (rd_ready) begin
      rd_item_r <= in_item;
    end
    if (mul_ready) begin
      mul_tag_r   <= '{op: rd_item_r.op, channel: rd_item_r.channel,
                       stime: rd_item_r.stime, last: rd_item_r.last};
      mul_prev_r  <= rd_inr ? DATA_W'(prev) : '0;
      mul_en_r    <= rd_inr && (rd_item_r.channel != '0);
      mul_diff_r  <= diff_sat;
      mul_pd_r    <= pd;
      mul_aprev_r <= aprev;
    end
    if (cmp_stage_ready) begin
      cmp_tag_r  <= mul_tag_r;
      cmp_prev_r <= mul_prev_r;
      cmp_en_r   <= mul_en_r;
      cmp_mag_r  <= mag;
      cmp_phi_r  <= prod[PW-1:GAIN_W];
    end
  end

endmodule

// ----- hw/rtl/sdct_frame.sv -----
// Frame controller: trigger latch, acquisition phase, store decision and result register.
`timescale 1ns / 1ps

module sdct_frame import sdct_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmp_valid,
  output logic      cmp_ready,
  input  sdct_cmp_t cmp_item,
  output logic      out_valid,
  input  logic      out_ready,
  output sdct_res_t out_res
);

  logic              take;
  logic              tp_eff;
  logic              trig_pend_r, trig_pend_nxt;
  sdct_phase_t       phase_r, phase_nxt;
  logic [DATA_W-1:0] last_time_r, last_time_nxt;
  logic              out_v_r;
  sdct_res_t         out_res_r, res_nxt;

  assign cmp_ready = !out_v_r || out_ready;
  assign take      = cmp_valid && cmp_ready;
  assign out_valid = out_v_r;
  assign out_res   = out_res_r;

  // Phase rules on the frame's last item
  always_comb begin
    tp_eff        = trig_pend_r || cmp_item.trig;
    trig_pend_nxt = tp_eff;
    phase_nxt     = phase_r;
    last_time_nxt = last_time_r;
    res_nxt       = '{channel: cmp_item.tag.channel, prev: cmp_item.prev,
                      frame_done: cmp_item.tag.last, store_request: 1'b0,
                      store_flag: 1'b0, store_time: '0};
    if (cmp_item.tag.last) begin
      case (cmp_item.tag.op)
        OP_ONLINE: begin
          case (phase_r)
            PH_WARMUP: begin
              phase_nxt = PH_FIRST;
            end
            PH_FIRST: begin
              res_nxt.store_request = 1'b1;
              res_nxt.store_flag    = 1'b1;
              res_nxt.store_time    = last_time_r;
              phase_nxt             = PH_STEADY;
            end
            default: begin
              res_nxt.store_request = 1'b1;
              res_nxt.store_flag    = tp_eff;
              res_nxt.store_time    = last_time_r;
            end
          endcase
          last_time_nxt = cmp_item.tag.stime;
          trig_pend_nxt = 1'b0;
        end
        OP_PREPULSE: begin
          trig_pend_nxt = 1'b1;
          last_time_nxt = PREPULSE_TIME;
          phase_nxt     = PH_WARMUP;
        end
        OP_POSTPULSE: begin
          res_nxt.store_request = 1'b1;
          res_nxt.store_flag    = 1'b1;
          res_nxt.store_time    = cmp_item.tag.stime;
          trig_pend_nxt         = 1'b0;
        end
        default: begin
          trig_pend_nxt = 1'b0;
        end
      endcase
    end
  end

  // Frame state, updated on each transfer from the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_pend_r <= 1'b0;
      phase_r     <= PH_WARMUP;
      last_time_r <= STORE_TIME_RST;
      out_v_r     <= 1'b0;
    end else begin
      if (take) begin
        trig_pend_r <= trig_pend_nxt;
        phase_r     <= phase_nxt;
        last_time_r <= last_time_nxt;
      end
      if (cmp_ready) begin
        out_v_r <= cmp_valid;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (take) begin
      out_res_r <= res_nxt;
    end
  end

endmodule

// ----- verif/tb.sv -----
// Self-checking bench for the second-difference change trigger: frames in, results compared.
`timescale 1ns / 1ps

module tb;
  import sdct_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;
  localparam int NUM_CH      = 64;
  localparam longint SAMPLE_MAX = 2147483647;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_wdata;

  sdct_in_if  in_chan ();
  sdct_out_if out_chan ();

  second_difference_change_trigger dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  // Mirror of the block state and its registers
  logic [DATA_W-1:0] held_samples [NUM_CH];
  logic [DATA_W-1:0] held_slopes  [NUM_CH];
  logic              trigger_armed;
  sdct_phase_t       acq_phase;
  logic [DATA_W-1:0] store_stamp;
  logic [GAIN_W-1:0] gain_setting;
  logic [TOL_W-1:0]  tol_setting;

  // Stimulus and scoreboard storage
  sdct_item_t  queued_samples [$];
  sdct_res_t   expected_results [$];
  sdct_item_t  held_item;
  int          wave_level [NUM_CH];
  int          wave_slope [NUM_CH];
  int          frame_clock;
  int unsigned items_queued;
  int unsigned mismatch_count;
  int unsigned quiet_cycles = 0;
  bit          steady_flow;

  // Clock: 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Advance the mirrored state by one item and return the result it produces
  function automatic sdct_res_t step_change_trigger(sdct_item_t it);
    sdct_res_t         res;
    longint            cur, prev, diff, dd;
    longint unsigned   mag, aprev, bound;
    res = '0;
    cur  = $signed(it.sample);
    prev = $signed(held_samples[it.channel]);
    res.channel    = it.channel;
    res.prev       = held_samples[it.channel];
    res.frame_done = it.last;
    // Channel 0 carries no compare
    if (it.channel != 0) begin
      diff = cur - prev;
      if (diff > SAMPLE_MAX) diff = SAMPLE_MAX;
      if (diff < SAMPLE_MIN) diff = SAMPLE_MIN;
      dd    = diff - longint'($signed(held_slopes[it.channel]));
      mag   = (dd < 0) ? -dd : dd;
      aprev = (prev < 0) ? -prev : prev;
      bound = ((64'(gain_setting) * aprev) >> 32) + 64'(tol_setting);
      if (mag > bound) trigger_armed = 1'b1;
      held_slopes[it.channel] = diff[DATA_W-1:0];
    end
    // Prepulse samples are not kept
    if (it.op != OP_PREPULSE) held_samples[it.channel] = it.sample;
    // Frame-end phase rules
    if (it.last) begin
      case (it.op)
        OP_ONLINE: begin
          if (acq_phase == PH_WARMUP) begin
            acq_phase = PH_FIRST;
          end else if (acq_phase == PH_FIRST) begin
            res.store_request = 1'b1;
            res.store_flag    = 1'b1;
            res.store_time    = store_stamp;
            acq_phase         = PH_STEADY;
          end else begin
            res.store_request = 1'b1;
            res.store_flag    = trigger_armed;
            res.store_time    = store_stamp;
          end
          store_stamp   = it.stime;
          trigger_armed = 1'b0;
        end
        OP_PREPULSE: begin
          trigger_armed = 1'b1;
          store_stamp   = PREPULSE_TIME;
          acq_phase     = PH_WARMUP;
        end
        OP_POSTPULSE: begin
          res.store_request = 1'b1;
          res.store_flag    = 1'b1;
          res.store_time    = it.stime;
          trigger_armed     = 1'b0;
        end
        default: begin
          trigger_armed = 1'b0;
        end
      endcase
    end
    return res;
  endfunction

  task automatic queue_item(sdct_op_t op, logic [CH_W-1:0] ch, logic [DATA_W-1:0] value,
                            logic [DATA_W-1:0] stamp, logic last);
    sdct_item_t it;
    it.op      = op;
    it.channel = ch;
    it.sample  = value;
    it.stime   = stamp;
    it.last    = last;
    queued_samples.push_back(it);
    items_queued++;
  endtask

  // Queue one frame of ascending channels; slow ramps with jitter, some jumps
  task automatic queue_frame(sdct_op_t op, int unsigned width, bit closed);
    int unsigned       first, c, ch, pick;
    logic [DATA_W-1:0] value;
    first = ($urandom_range(9) < 7) ? 0 : $urandom_range(NUM_CH - width);
    frame_clock += 1000 + $urandom_range(15);
    if ($urandom_range(19) == 0) frame_clock = $urandom;
    for (c = 0; c < width; c++) begin
      ch   = first + c;
      pick = $urandom_range(99);
      if (pick < 5) begin
        value = $urandom;
      end else begin
        if (pick < 13) wave_level[ch] += int'($urandom_range(32'hF_FFFF)) - 32'h8_0000;
        else wave_level[ch] += wave_slope[ch];
        value = wave_level[ch] + int'($urandom_range(6)) - 3;
      end
      queue_item(op, CH_W'(ch), value, frame_clock, closed && (c == width - 1));
    end
  endtask

  // Mostly well-formed frames, some unterminated frames and loose noise items
  task automatic queue_traffic(int unsigned count);
    int unsigned target, pick, width;
    sdct_op_t    op;
    target = items_queued + count;
    while (items_queued < target) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        queue_item(sdct_op_t'($urandom_range(3)), CH_W'($urandom), $urandom, $urandom,
                   1'($urandom_range(1)));
      end else begin
        pick  = $urandom_range(99);
        op    = (pick < 68) ? OP_ONLINE : (pick < 78) ? OP_PREPULSE :
                (pick < 89) ? OP_POSTPULSE : OP_OTHER;
        width = ($urandom_range(49) == 0) ? NUM_CH : $urandom_range(8, 1);
        queue_frame(op, width, $urandom_range(24) != 0);
      end
    end
  endtask

  // Hold until every queued item has been sent and every result has come back;
  // look between edges so the driver and monitor updates have settled
  task automatic drain_traffic();
    while (queued_samples.size() != 0 || in_chan.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic load_register(sdct_cfg_t idx, logic [DATA_W-1:0] value);
    drain_traffic();
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == CFG_GAIN) gain_setting = value;
    else tol_setting = value[TOL_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic note_mismatch(string label, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s expected %h, got %h", $time, label, want, got);
  endtask

  task automatic check_field(string label, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) note_mismatch(label, want, got);
  endtask

  // Input driver: present the next queued item, with random gaps unless steady_flow is set
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        expected_results.push_back(step_change_trigger(held_item));
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (queued_samples.size() != 0 && (steady_flow || $urandom_range(99) >= 17)) begin
          held_item = queued_samples.pop_front();
          in_chan.valid        <= 1'b1;
          in_chan.operation    <= held_item.op;
          in_chan.channel      <= held_item.channel;
          in_chan.sample_value <= held_item.sample;
          in_chan.sample_time  <= held_item.stime;
          in_chan.last_channel <= held_item.last;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Result sink: stall at random unless steady_flow is set
  always @(posedge clk) begin
    out_chan.ready <= steady_flow || ($urandom_range(99) >= 17);
  end

  // Compare each result transfer against the oldest expectation
  always @(posedge clk) begin : watch_results
    sdct_res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch("unexpected result on channel", '0, 32'(out_chan.channel_out));
      end else begin
        want = expected_results.pop_front();
        check_field("channel_out", 32'(want.channel), 32'(out_chan.channel_out));
        check_field("previous_value", want.prev, out_chan.previous_value);
        check_field("frame_done", 32'(want.frame_done), 32'(out_chan.frame_done));
        check_field("store_request", 32'(want.store_request), 32'(out_chan.store_request));
        check_field("store_flag", 32'(want.store_flag), 32'(out_chan.store_flag));
        check_field("store_time", want.store_time, out_chan.store_time);
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int idx;
    // Known levels on every input before the first edge
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_GAIN;
    cfg_wdata            = '0;
    in_chan.valid        = 1'b0;
    in_chan.operation    = OP_ONLINE;
    in_chan.channel      = '0;
    in_chan.sample_value = '0;
    in_chan.sample_time  = '0;
    in_chan.last_channel = 1'b0;
    out_chan.ready       = 1'b0;
    steady_flow          = 1'b0;
    mismatch_count       = 0;
    items_queued         = 0;
    frame_clock          = 0;
    gain_setting         = GAIN_RST;
    tol_setting          = TOL_RST;
    trigger_armed        = 1'b0;
    acq_phase            = PH_WARMUP;
    store_stamp          = STORE_TIME_RST;
    for (idx = 0; idx < NUM_CH; idx++) begin
      held_samples[idx] = '0;
      held_slopes[idx]  = '0;
      wave_level[idx]   = int'($urandom) >>> 4;
      wave_slope[idx]   = $urandom_range(8191) - 4096;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Warmup frame with zero and both sample extremes
    queue_item(OP_ONLINE, 6'd0, 32'h0000_0000, 32'h0000_0000, 1'b0);
    queue_item(OP_ONLINE, 6'd1, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
    queue_item(OP_ONLINE, 6'd2, 32'h8000_0000, 32'h0000_0000, 1'b1);
    // Full-swing steps saturate the first difference; first store of the phase
    queue_item(OP_ONLINE, 6'd0, 32'h0000_0001, 32'h7FFF_FFFF, 1'b0);
    queue_item(OP_ONLINE, 6'd1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    queue_item(OP_ONLINE, 6'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    // Steady stores, top channel, flat sample
    queue_item(OP_ONLINE, 6'd1, 32'h8000_0000, 32'h8000_0000, 1'b0);
    queue_item(OP_ONLINE, 6'd63, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
    queue_item(OP_ONLINE, 6'd1, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
    // Prepulse leaves samples alone and rearms the trigger
    queue_item(OP_PREPULSE, 6'd0, 32'h1234_5678, 32'h0000_1000, 1'b0);
    queue_item(OP_PREPULSE, 6'd1, 32'h5555_AAAA, 32'h0000_1000, 1'b1);
    // Postpulse stores with its own time
    queue_item(OP_POSTPULSE, 6'd1, 32'hAAAA_5555, 32'h8000_0000, 1'b1);
    // Offline frame only clears the trigger
    queue_item(OP_OTHER, 6'd0, 32'h0001_0000, 32'h0000_2000, 1'b0);
    queue_item(OP_OTHER, 6'd5, 32'hFFFF_0000, 32'h0000_2000, 1'b1);
    // Online again after prepulse: warmup, first store, steady store
    queue_item(OP_ONLINE, 6'd0, 32'h0000_0100, 32'h0000_3000, 1'b1);
    queue_item(OP_ONLINE, 6'd1, 32'h0000_0200, 32'h0000_4000, 1'b1);
    queue_item(OP_ONLINE, 6'd1, 32'h0000_0300, 32'h0000_5000, 1'b1);
    queue_traffic(300);

    // Zero bound: any change of slope fires
    load_register(CFG_GAIN, '0);
    load_register(CFG_TOL, '0);
    queue_traffic(300);

    // Widest bound
    load_register(CFG_GAIN, 32'hFFFF_FFFF);
    load_register(CFG_TOL, 32'h7FFF_FFFF);
    queue_traffic(250);

    // Random gain with small tolerance, back-to-back transfers
    load_register(CFG_GAIN, $urandom);
    load_register(CFG_TOL, $urandom_range(32'h3_FFFF));
    steady_flow = 1'b1;
    queue_traffic(300);
    drain_traffic();
    steady_flow = 1'b0;

    load_register(CFG_GAIN, 32'h8000_0000);
    load_register(CFG_TOL, $urandom);
    queue_traffic(300);

    load_register(CFG_GAIN, GAIN_RST);
    load_register(CFG_TOL, 32'h0001_0000);
    queue_traffic(300);

    drain_traffic();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/sdct_pkg.sv
hw/rtl/sdct_if.sv
hw/rtl/sdct_ram.sv
hw/rtl/sdct_datapath.sv
hw/rtl/sdct_frame.sv
hw/rtl/second_difference_change_trigger.sv
verif/tb.sv
